>>> hw/rtl/atwa_pkg.sv
// Shared constants, divider source codes and control/status structs for the
// temperature window average block. No dependencies.
`default_nettype none

package atwa_pkg;

  localparam int ADC_W       = 10;
  localparam int ADC_SUM_W   = 11;
  localparam int TEMP_W      = 18;
  localparam int WINDOW_DEF  = 30;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // Divider-based conversion: t = floor(DIV_GAIN*s / (DIV_FULL - s)) - TEMP_OFFSET
  localparam int DIV_GAIN    = 24000;
  localparam int DIV_FULL    = 2048;
  localparam int CONV_NUM_W  = 26;
  localparam int CONV_DEN_W  = 12;
  localparam int TEMP_OFFSET = 17024;
  localparam int TEMP_MAX    = 131071;
  localparam int Q_SAT       = TEMP_MAX + TEMP_OFFSET;

  typedef enum logic [1:0] {
    DIV_CONV = 2'd0,
    DIV_AVG  = 2'd1,
    DIV_DEV  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_t;
    logic     take_avg;
    logic     take_dev;
    logic     write_win;
    logic     walk_clr;
    logic     walk_sum;
    logic     walk_dev;
    logic     load_out;
  } atwa_cmd_t;

  typedef struct packed {
    logic div_done;
    logic filled;
    logic store_last;
    logic walk_last;
  } atwa_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/adc_temperature_window_average.sv
// Top level of the temperature window average block.
// Depends on atwa_pkg, atwa_ctrl, atwa_dp (and atwa_div below it).
//
// Each input beat carries two 10-bit converter readings of one sensor divider.
// Their sum s becomes a temperature in 1/64 degree C as
// floor(24000*s/(2048-s)) - 17024, saturated at 131071; it enters a window of
// WINDOW samples (the first sample after reset fills the whole window). Each
// input beat gives one output beat: the new temperature, the floored window
// mean and the floored mean absolute deviation from the exact mean. One
// sample is processed at a time. From one accepted input beat to the next
// possible one a sample passes through the 26-step bit-serial conversion
// divider, two walks over the single-port window memory, the reciprocal
// multiplies of the mean and the deviation, the accept, the window write and
// the output load; the first sample writes every window entry. A stalled
// output beat holds back the next one for as long as it is held. The finished
// beat waits in an output register while the next input is taken.
`default_nettype none

module adc_temperature_window_average #(
  parameter int WINDOW = atwa_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [9:0] adc_a, [19:10] adc_b, [23:20] zero
  input  logic [atwa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [17:0] current_temp, [35:18] average_temp, [53:36] mean_deviation, [55:54] zero
  output logic [atwa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  import atwa_pkg::*;

  atwa_cmd_t                cmd;
  atwa_sts_t                sts;
  logic signed [TEMP_W-1:0] current_temp;
  logic signed [TEMP_W-1:0] average_temp;
  logic [TEMP_W-1:0]        mean_deviation;

  atwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  atwa_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .adc_a          (s_axis_tdata[ADC_W-1:0]),
    .adc_b          (s_axis_tdata[2*ADC_W-1:ADC_W]),
    .current_temp   (current_temp),
    .average_temp   (average_temp),
    .mean_deviation (mean_deviation)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 3 * TEMP_W)'(0), mean_deviation,
                         average_temp, current_temp};

endmodule

`default_nettype wire

>>> hw/rtl/atwa_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Uses no package items.
`default_nettype none

module atwa_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_diff;
  logic              fits;

  assign trial      = {rem, quo[NUM_W-1]};
  assign trial_diff = trial - {1'b0, den_q};
  assign fits       = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atwa_dp.sv
// Datapath: conversion divider, sample window memory, sum and deviation walks,
// reciprocal multipliers for mean and deviation, output registers.
// Depends on atwa_pkg, atwa_div.
`default_nettype none

module atwa_dp #(
  parameter int WINDOW = atwa_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  atwa_pkg::atwa_cmd_t                 cmd,
  output atwa_pkg::atwa_sts_t                 sts,
  input  logic [atwa_pkg::ADC_W-1:0]          adc_a,
  input  logic [atwa_pkg::ADC_W-1:0]          adc_b,
  output logic signed [atwa_pkg::TEMP_W-1:0]  current_temp,
  output logic signed [atwa_pkg::TEMP_W-1:0]  average_temp,
  output logic [atwa_pkg::TEMP_W-1:0]         mean_deviation
);

  import atwa_pkg::*;

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int ADDR_W = LOG_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = TEMP_W + LOG_W;
  localparam int TERM_W = SUM_W + 2;
  localparam int DEV_W  = TEMP_W + 1 + 2 * LOG_W;
  localparam int SQ_LOG = $clog2(WINDOW * WINDOW);
  localparam int K_AVG  = SUM_W + LOG_W;
  localparam int K_DEV  = DEV_W + SQ_LOG;
  localparam int MA_W   = SUM_W + 2;
  localparam int MD_W   = DEV_W + 2;
  localparam int AP_W   = SUM_W + MA_W;
  localparam int DP_W   = DEV_W + MD_W;
  localparam logic signed [TERM_W-1:0] WIN_S = TERM_W'(WINDOW);
  // ceil(2^K / d): exact floor division for every numerator of the given width
  localparam longint M_AVG = ((longint'(1) << K_AVG) + longint'(WINDOW) - 1) /
                             longint'(WINDOW);
  localparam longint M_DEV = ((longint'(1) << K_DEV) + longint'(WINDOW * WINDOW) - 1) /
                             longint'(WINDOW * WINDOW);
  localparam logic [MA_W-1:0] M_AVG_C = MA_W'(M_AVG);
  localparam logic [MD_W-1:0] M_DEV_C = MD_W'(M_DEV);

  logic [TEMP_W-1:0]        mem [WINDOW];
  logic signed [TEMP_W-1:0] mem_q;

  logic [ADC_SUM_W-1:0]     s;
  logic signed [TEMP_W-1:0] t;
  logic signed [TEMP_W-1:0] avg;
  logic [TEMP_W-1:0]        devo;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [DEV_W-1:0]         dev_acc;
  logic [CNT_W-1:0]         cnt;
  logic [ADDR_W-1:0]        ptr;
  logic                     filled;

  logic [CONV_NUM_W-1:0]    conv_num;
  logic [CONV_DEN_W-1:0]    conv_den;
  logic                     div_go;
  logic                     div_done;
  logic [CONV_NUM_W-1:0]    quo;

  logic                     rc_go;
  logic                     rc_v1;
  logic                     rc_done;
  logic                     rc_is_avg;
  logic [SUM_W-1:0]         avg_num;
  logic [DEV_W-1:0]         rc_num;
  logic [DEV_W-1:0]         rc_q;
  logic [AP_W-1:0]          avg_prod;
  logic [DP_W-1:0]          dev_prod;

  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_abs;
  logic signed [TERM_W-1:0] term;
  logic [TERM_W-1:0]        term_abs;
  logic                     walking;
  logic                     acc_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     store_last;
  logic                     walk_last;

  assign store_last = (cnt == CNT_W'(WINDOW - 1));
  assign walk_last  = (cnt == CNT_W'(WINDOW));
  assign walking    = cmd.walk_sum || cmd.walk_dev;
  assign acc_en     = walking && (cnt != '0);
  assign wr_addr    = filled ? ptr : cnt[ADDR_W-1:0];

  assign sum_neg  = sum_acc[SUM_W-1];
  assign sum_abs  = sum_neg ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
  assign term     = TERM_W'(mem_q) * WIN_S - TERM_W'(sum_acc);
  assign term_abs = term[TERM_W-1] ? TERM_W'(-term) : TERM_W'(term);

  assign conv_num = CONV_NUM_W'(s) * CONV_NUM_W'(DIV_GAIN);
  assign conv_den = CONV_DEN_W'(DIV_FULL) - CONV_DEN_W'(s);
  assign div_go   = cmd.div_start && (cmd.div_sel == DIV_CONV);
  assign rc_go    = cmd.div_start && (cmd.div_sel != DIV_CONV);

  // negative sum: ceil(|S| / WINDOW), negated later, gives the floor
  assign avg_num  = sum_neg ? sum_abs + SUM_W'(WINDOW - 1) : sum_abs;
  assign avg_prod = AP_W'(rc_num[SUM_W-1:0]) * AP_W'(M_AVG_C);
  assign dev_prod = DP_W'(rc_num) * DP_W'(M_DEV_C);

  atwa_div #(
    .NUM_W (CONV_NUM_W),
    .DEN_W (CONV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (conv_num),
    .den   (conv_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      ptr     <= '0;
      filled  <= 1'b0;
      rc_v1   <= 1'b0;
      rc_done <= 1'b0;
    end else begin
      rc_v1   <= rc_go;
      rc_done <= rc_v1;
      if (cmd.walk_clr) begin
        cnt <= '0;
      end else if (walking || (cmd.write_win && !filled)) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.write_win && filled) begin
        ptr <= (ptr == ADDR_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;
      end
      if (cmd.write_win && !filled && store_last) begin
        filled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_win) begin
      mem[wr_addr] <= t;
    end
    if (walking && !walk_last) begin
      mem_q <= mem[cnt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s       <= ADC_SUM_W'(adc_a) + ADC_SUM_W'(adc_b);
      sum_acc <= '0;
      dev_acc <= '0;
    end else begin
      if (cmd.walk_sum && acc_en) begin
        sum_acc <= sum_acc + SUM_W'(mem_q);
      end
      if (cmd.walk_dev && acc_en) begin
        dev_acc <= dev_acc + DEV_W'(term_abs);
      end
    end
    if (rc_go) begin
      rc_num    <= (cmd.div_sel == DIV_AVG) ? DEV_W'(avg_num) : dev_acc;
      rc_is_avg <= (cmd.div_sel == DIV_AVG);
    end
    if (rc_v1) begin
      rc_q <= rc_is_avg ? DEV_W'(avg_prod >> K_AVG) : DEV_W'(dev_prod >> K_DEV);
    end
    if (cmd.take_t) begin
      t <= (quo > CONV_NUM_W'(Q_SAT)) ? TEMP_W'(TEMP_MAX) :
           TEMP_W'(quo - CONV_NUM_W'(TEMP_OFFSET));
    end
    if (cmd.take_avg) begin
      avg <= sum_neg ? TEMP_W'(-rc_q) : TEMP_W'(rc_q);
    end
    if (cmd.take_dev) begin
      devo <= (|rc_q[DEV_W-1:TEMP_W]) ? '1 : rc_q[TEMP_W-1:0];
    end
    if (cmd.load_out) begin
      current_temp   <= t;
      average_temp   <= avg;
      mean_deviation <= devo;
    end
  end

  always_comb begin
    sts.div_done   = div_done || rc_done;
    sts.filled     = filled;
    sts.store_last = store_last;
    sts.walk_last  = walk_last;
  end

endmodule

`default_nettype wire

>>> hw/rtl/atwa_ctrl.sv
// Controller: sequences one sample through conversion, window update,
// sum walk, mean division, deviation walk, deviation division and output. Depends on atwa_pkg.
`default_nettype none

module atwa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  atwa_pkg::atwa_sts_t sts,
  output atwa_pkg::atwa_cmd_t cmd
);

  import atwa_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_CONV_GO   = 11'b00000000010,
    ST_CONV_WAIT = 11'b00000000100,
    ST_STORE     = 11'b00000001000,
    ST_SUM       = 11'b00000010000,
    ST_AVG_GO    = 11'b00000100000,
    ST_AVG_WAIT  = 11'b00001000000,
    ST_DEV       = 11'b00010000000,
    ST_DEV_GO    = 11'b00100000000,
    ST_DEV_WAIT  = 11'b01000000000,
    ST_OUT       = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_CONV;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CONV_GO;
        end
      end
      ST_CONV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_CONV_WAIT;
      end
      ST_CONV_WAIT: begin
        if (sts.div_done) begin
          cmd.take_t   = 1'b1;
          cmd.walk_clr = 1'b1;
          state_next   = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.write_win = 1'b1;
        if (sts.filled || sts.store_last) begin
          cmd.walk_clr = 1'b1;
          state_next   = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.walk_sum = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        cmd.div_sel   = DIV_AVG;
        cmd.div_start = 1'b1;
        cmd.walk_clr  = 1'b1;
        state_next    = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.take_avg = 1'b1;
          state_next   = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd.walk_dev = 1'b1;
        if (sts.walk_last) begin
          state_next = ST_DEV_GO;
        end
      end
      ST_DEV_GO: begin
        cmd.div_sel   = DIV_DEV;
        cmd.div_start = 1'b1;
        state_next    = ST_DEV_WAIT;
      end
      ST_DEV_WAIT: begin
        if (sts.div_done) begin
          cmd.take_dev = 1'b1;
          state_next   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/atwa_checker.sv
// Port-level checks for the temperature window average block, bound to the
// top level. Depends on atwa_pkg.
`default_nettype none

module atwa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [atwa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import atwa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  a_temp_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[TEMP_W-1:0]) >= -TEMP_OFFSET)
    else $error("current temperature below conversion floor");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:3*TEMP_W] == '0)
    else $error("output padding not zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output beat valid after reset");

endmodule

bind adc_temperature_window_average atwa_checker u_atwa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> verif/adc_temperature_window_average_tb.sv
// Self-checking testbench for adc_temperature_window_average: directed and random
// divider readings, a predicted temperature/mean/deviation per beat, random stalls.
// Depends on atwa_pkg and the block's RTL.
`timescale 1ns / 100ps

module adc_temperature_window_average_tb;
  import atwa_pkg::*;

  localparam int WIN         = WINDOW_DEF;
  localparam int N_RANDOM    = 1750;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN       = 400;

  typedef struct {
    logic signed [TEMP_W-1:0] cur;
    logic signed [TEMP_W-1:0] avg;
    logic        [TEMP_W-1:0] dev;
  } temp_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  adc_temperature_window_average dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  logic [IN_TDATA_W-1:0] pending_readings[$];
  temp_result_t          expected_temps[$];
  int                    n_sent = 0;
  int                    errors = 0;
  int                    stall_cycles = 0;
  logic                  calm;

  // predictor state
  longint temp_history[WIN];
  bit     history_primed = 1'b0;

  assign calm = (n_sent >= 700 && n_sent < 1000);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint convert_reading(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
    longint s;
    longint t;
    s = longint'(a) + longint'(b);
    t = (longint'(DIV_GAIN) * s) / (longint'(DIV_FULL) - s) - TEMP_OFFSET;
    if (t > TEMP_MAX) t = TEMP_MAX;
    return t;
  endfunction

  function automatic temp_result_t predict_sample(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
    temp_result_t r;
    longint t;
    longint sum;
    longint mean;
    longint dev;
    longint d;
    t = convert_reading(a, b);
    if (!history_primed) begin
      for (int i = 0; i < WIN; i++) temp_history[i] = t;
      history_primed = 1'b1;
    end else begin
      for (int i = 1; i < WIN; i++) temp_history[i-1] = temp_history[i];
      temp_history[WIN-1] = t;
    end
    sum = 0;
    for (int i = 0; i < WIN; i++) sum += temp_history[i];
    mean = sum / WIN;
    if ((sum % WIN) != 0 && sum < 0) mean -= 1;
    dev = 0;
    for (int i = 0; i < WIN; i++) begin
      d = WIN * temp_history[i] - sum;
      dev += (d < 0) ? -d : d;
    end
    dev = dev / (WIN * WIN);
    if (dev > 262143) dev = 262143;
    r.cur = t[TEMP_W-1:0];
    r.avg = mean[TEMP_W-1:0];
    r.dev = dev[TEMP_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_reading(int a, int b);
    logic [ADC_W-1:0] fa;
    logic [ADC_W-1:0] fb;
    fa = a[ADC_W-1:0];
    fb = b[ADC_W-1:0];
    return {{(IN_TDATA_W - 2*ADC_W){1'b0}}, fb, fa};
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    if (errors < 10)
      $display("mismatch beat %0d %s: expected %0d, got %0d", n_sent, field, want, got);
    errors++;
  endtask

  // input driver; prediction happens on each accepted beat
  always @(posedge clk) begin : drive
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_temps.push_back(predict_sample(s_axis_tdata[ADC_W-1:0],
                                                s_axis_tdata[2*ADC_W-1:ADC_W]));
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_readings.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_readings.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin : check
    temp_result_t want;
    logic signed [TEMP_W-1:0] got_cur;
    logic signed [TEMP_W-1:0] got_avg;
    logic        [TEMP_W-1:0] got_dev;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_cur = m_axis_tdata[TEMP_W-1:0];
      got_avg = m_axis_tdata[2*TEMP_W-1:TEMP_W];
      got_dev = m_axis_tdata[3*TEMP_W-1:2*TEMP_W];
      if (expected_temps.size() == 0) begin
        if (errors < 10) $display("unexpected output beat: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_temps.pop_front();
        if (got_cur != want.cur) report_mismatch("current_temp", want.cur, got_cur);
        if (got_avg != want.avg) report_mismatch("average_temp", want.avg, got_avg);
        if (got_dev != want.dev) report_mismatch("mean_deviation", want.dev, got_dev);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int base_a;
    int base_b;
    int a;
    int b;
    int mode;
    // first sample fills the window with the lowest temperature
    pending_readings.push_back(pack_reading(0, 0));
    pending_readings.push_back(pack_reading(1023, 1023));
    pending_readings.push_back(pack_reading(1023, 1022));
    pending_readings.push_back(pack_reading(0, 1));
    pending_readings.push_back(pack_reading(1, 0));
    // saturation edge: s = 1762 stays below, s = 1763 saturates
    pending_readings.push_back(pack_reading(881, 881));
    pending_readings.push_back(pack_reading(882, 881));
    pending_readings.push_back(pack_reading(400, 400));
    pending_readings.push_back(pack_reading(512, 512));
    pending_readings.push_back(pack_reading(682, 341));
    pending_readings.push_back(pack_reading(1023, 0));
    pending_readings.push_back(pack_reading(0, 1023));
    pending_readings.push_back(pack_reading(10'h2AA, 10'h155));
    pending_readings.push_back(pack_reading(10'h155, 10'h2AA));
    // swing between extremes for a large deviation
    for (int i = 0; i < 8; i++) begin
      pending_readings.push_back(pack_reading(0, 0));
      pending_readings.push_back(pack_reading(1023, 1023));
    end

    base_a = 420;
    base_b = 420;
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(29) == 0) begin
        base_a = $urandom_range(1023);
        base_b = $urandom_range(1023);
      end
      mode = $urandom_range(9);
      if (mode < 3) begin
        a = $urandom_range(1023);
        b = $urandom_range(1023);
      end else if (mode < 9) begin
        // sensor near a base level that jumps now and then, with a little noise
        a = base_a + $urandom_range(16) - 8;
        b = base_b + $urandom_range(16) - 8;
        if (a < 0) a = 0;
        if (a > 1023) a = 1023;
        if (b < 0) b = 0;
        if (b > 1023) b = 1023;
      end else begin
        a = $urandom_range(1) ? 1023 : 0;
        b = $urandom_range(1) ? 1023 : 0;
      end
      pending_readings.push_back(pack_reading(a, b));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_readings.size() != 0 || s_axis_tvalid || expected_temps.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0 && expected_temps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
